// ===== src/tclk_pkg.sv =====
// shared types, constants and set-step functions for the twelve-hour clock
package tclk_pkg;

  localparam int COUNT_WIDTH = 10;
  localparam int REG_WIDTH = 10;
  localparam int DEBOUNCE_WIDTH = 8;
  localparam int BUTTON_WIDTH = 5;
  localparam int CMP_WIDTH = (COUNT_WIDTH > REG_WIDTH) ? COUNT_WIDTH : REG_WIDTH;

  typedef logic [COUNT_WIDTH-1:0] count_t;
  typedef logic [REG_WIDTH-1:0] reg_t;
  typedef logic [DEBOUNCE_WIDTH-1:0] debounce_t;
  typedef logic [BUTTON_WIDTH-1:0] buttons_t;
  typedef logic [CMP_WIDTH-1:0] cmp_t;

  typedef enum logic {
    OP_TICK   = 1'b0,
    OP_BUTTON = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    REG_SECOND_LEN            = 2'd0,
    REG_SETTLE_LEN            = 2'd1,
    REG_REPEAT_HOLD_TICKS     = 2'd2,
    REG_REPEAT_INTERVAL_TICKS = 2'd3
  } reg_index_t;

  localparam int BTN_MIN  = 0;
  localparam int BTN_SEC  = 1;
  localparam int BTN_DEC  = 2;
  localparam int BTN_HOUR = 3;
  localparam int BTN_INC  = 4;

  localparam logic [3:0] HOUR_FIRST = 4'd1;
  localparam logic [3:0] HOUR_LAST  = 4'd12;
  localparam logic [5:0] SIXTY_LAST = 6'd59;

  localparam reg_t      TPS_RESET      = reg_t'(100);
  localparam debounce_t DEBOUNCE_RESET = debounce_t'(5);
  localparam reg_t      HOLD_RESET     = reg_t'(100);
  localparam reg_t      INTERVAL_RESET = reg_t'(50);

  typedef struct packed {
    logic [3:0] hours;
    logic [5:0] minutes;
    logic [5:0] seconds;
  } clock_time_t;

  typedef struct packed {
    opcode_t  opcode;
    buttons_t buttons;
  } event_t;

  typedef struct packed {
    logic       enable;
    reg_index_t index;
    reg_t       data;
  } cfg_write_t;

  function automatic logic [5:0] step_sixty(input logic [5:0] v, input buttons_t btn);
    logic [5:0] r;
    r = v;
    if (btn[BTN_INC]) begin
      r = (v >= SIXTY_LAST) ? 6'd0 : v + 6'd1;
    end else if (btn[BTN_DEC]) begin
      r = (v == 6'd0) ? SIXTY_LAST : v - 6'd1;
    end
    return r;
  endfunction

  function automatic logic [3:0] step_hours(input logic [3:0] h, input buttons_t btn);
    logic [3:0] r;
    r = h;
    if (btn[BTN_INC]) begin
      r = (h >= HOUR_LAST) ? HOUR_FIRST : h + 4'd1;
    end else if (btn[BTN_DEC]) begin
      r = (h <= HOUR_FIRST) ? HOUR_LAST : h - 4'd1;
    end
    return r;
  endfunction

  function automatic clock_time_t set_step(input clock_time_t t, input buttons_t btn);
    clock_time_t r;
    r = t;
    if (btn[BTN_MIN]) begin
      r.minutes = step_sixty(t.minutes, btn);
    end
    if (btn[BTN_SEC]) begin
      r.seconds = step_sixty(t.seconds, btn);
    end
    if (btn[BTN_HOUR]) begin
      r.hours = step_hours(t.hours, btn);
    end
    return r;
  endfunction

endpackage

// ===== src/tclk_in_stage.sv =====
// input register for incoming event words
module tclk_in_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              opcode,
  input  logic [4:0]        buttons,
  input  logic              take,
  output logic              ev_valid,
  output tclk_pkg::event_t  ev
);

  logic accept;
  logic ev_valid_next;

  assign in_stall = ev_valid && !take;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    ev_valid_next = ev_valid;
    if (accept) begin
      ev_valid_next = 1'b1;
    end else if (take) begin
      ev_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ev_valid <= 1'b0;
    end else begin
      ev_valid <= ev_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ev.opcode  <= tclk_pkg::opcode_t'(opcode);
      ev.buttons <= buttons;
    end
  end

endmodule

// ===== src/tclk_core.sv =====
// clock state, debounce and auto repeat update with configuration registers
module tclk_core (
  input  logic                   clk,
  input  logic                   rst,
  input  tclk_pkg::cfg_write_t   cfg,
  input  logic                   fire,
  input  tclk_pkg::event_t       ev,
  output tclk_pkg::clock_time_t  result
);

  tclk_pkg::reg_t      second_len;
  tclk_pkg::debounce_t settle_len;
  tclk_pkg::reg_t      repeat_hold_ticks;
  tclk_pkg::reg_t      repeat_interval_ticks;

  tclk_pkg::clock_time_t now;
  tclk_pkg::count_t      subsecond_count;
  tclk_pkg::buttons_t    raw_buttons;
  tclk_pkg::buttons_t    stable_buttons;
  tclk_pkg::debounce_t   debounce_left;
  tclk_pkg::count_t      hold_count;
  tclk_pkg::count_t      repeat_count;

  tclk_pkg::clock_time_t now_next;
  tclk_pkg::count_t      subsecond_count_next;
  tclk_pkg::buttons_t    raw_buttons_next;
  tclk_pkg::buttons_t    stable_buttons_next;
  tclk_pkg::debounce_t   debounce_left_next;
  tclk_pkg::count_t      hold_count_next;
  tclk_pkg::count_t      repeat_count_next;

  tclk_pkg::count_t subsecond_inc;
  logic             second_done;

  assign subsecond_inc = subsecond_count + tclk_pkg::count_t'(1);
  assign second_done   = tclk_pkg::cmp_t'(subsecond_inc) >= tclk_pkg::cmp_t'(second_len);

  always_ff @(posedge clk) begin
    if (rst) begin
      second_len            <= tclk_pkg::TPS_RESET;
      settle_len            <= tclk_pkg::DEBOUNCE_RESET;
      repeat_hold_ticks     <= tclk_pkg::HOLD_RESET;
      repeat_interval_ticks <= tclk_pkg::INTERVAL_RESET;
    end else if (cfg.enable) begin
      unique case (cfg.index)
        tclk_pkg::REG_SECOND_LEN:            second_len            <= cfg.data;
        tclk_pkg::REG_SETTLE_LEN:            settle_len            <= cfg.data[7:0];
        tclk_pkg::REG_REPEAT_HOLD_TICKS:     repeat_hold_ticks     <= cfg.data;
        tclk_pkg::REG_REPEAT_INTERVAL_TICKS: repeat_interval_ticks <= cfg.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    now_next             = now;
    subsecond_count_next = subsecond_count;
    raw_buttons_next     = raw_buttons;
    stable_buttons_next  = stable_buttons;
    debounce_left_next   = debounce_left;
    hold_count_next      = hold_count;
    repeat_count_next    = repeat_count;
    if (ev.opcode == tclk_pkg::OP_BUTTON) begin
      raw_buttons_next   = ev.buttons;
      debounce_left_next = settle_len;
    end else begin
      // clock runs only while no debounced button is held
      if (stable_buttons == '0) begin
        if (second_done) begin
          subsecond_count_next = '0;
          if (now.seconds >= tclk_pkg::SIXTY_LAST) begin
            now_next.seconds = 6'd0;
            if (now.minutes >= tclk_pkg::SIXTY_LAST) begin
              now_next.minutes = 6'd0;
              now_next.hours = (now.hours >= tclk_pkg::HOUR_LAST) ? tclk_pkg::HOUR_FIRST
                                                                  : now.hours + 4'd1;
            end else begin
              now_next.minutes = now.minutes + 6'd1;
            end
          end else begin
            now_next.seconds = now.seconds + 6'd1;
          end
        end else begin
          subsecond_count_next = subsecond_inc;
        end
      end
      // debounce countdown
      if (debounce_left != '0) begin
        if (debounce_left == tclk_pkg::debounce_t'(1)) begin
          stable_buttons_next = raw_buttons;
          now_next = tclk_pkg::set_step(now_next, raw_buttons);
        end
        debounce_left_next = debounce_left - tclk_pkg::debounce_t'(1);
      end
      // auto repeat
      if (stable_buttons_next != '0 && debounce_left_next == '0) begin
        if (tclk_pkg::cmp_t'(hold_count) < tclk_pkg::cmp_t'(repeat_hold_ticks)) begin
          hold_count_next = hold_count + tclk_pkg::count_t'(1);
        end else if (tclk_pkg::cmp_t'(repeat_count) < tclk_pkg::cmp_t'(repeat_interval_ticks)) begin
          repeat_count_next = repeat_count + tclk_pkg::count_t'(1);
        end else begin
          repeat_count_next = '0;
          now_next = tclk_pkg::set_step(now_next, stable_buttons_next);
        end
      end else begin
        hold_count_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      now.hours       <= tclk_pkg::HOUR_FIRST;
      now.minutes     <= 6'd0;
      now.seconds     <= 6'd0;
      subsecond_count <= '0;
      raw_buttons     <= '0;
      stable_buttons  <= '0;
      debounce_left   <= tclk_pkg::DEBOUNCE_RESET;
      hold_count      <= '0;
      repeat_count    <= '0;
    end else if (fire) begin
      now             <= now_next;
      subsecond_count <= subsecond_count_next;
      raw_buttons     <= raw_buttons_next;
      stable_buttons  <= stable_buttons_next;
      debounce_left   <= debounce_left_next;
      hold_count      <= hold_count_next;
      repeat_count    <= repeat_count_next;
    end
  end

  assign result = now_next;

endmodule

// ===== src/tclk_out_stage.sv =====
// result register holding the time word until the consumer takes it
module tclk_out_stage (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   load,
  input  tclk_pkg::clock_time_t  result,
  output logic                   out_ready,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [3:0]             hours,
  output logic [5:0]             minutes,
  output logic [5:0]             seconds
);

  logic out_valid_next;

  assign out_ready = !out_valid || !out_stall;

  always_comb begin
    out_valid_next = out_valid;
    if (load) begin
      out_valid_next = 1'b1;
    end else if (!out_stall) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      hours   <= result.hours;
      minutes <= result.minutes;
      seconds <= result.seconds;
    end
  end

endmodule

// ===== src/twelve_hour_clock_with_set_buttons.sv =====
// top level of the twelve-hour clock with debounced set buttons
// an accepted word goes into the input register, and its time word into the output register
// throughput: one word per cycle while the output is not stalled, set by the single state update stage in tclk_core
// a stalled output holds one word while the input register takes the next
// reset clears the time to 1:00:00, the buttons and the subsecond, hold and repeat counts, and sets
// the debounce count and the registers to their defaults; no words are held after reset
module twelve_hour_clock_with_set_buttons (
  input  logic       clk,
  input  logic       rst,
  input  logic       write_enable,
  input  logic [1:0] write_index,
  input  logic [9:0] write_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       opcode,
  input  logic [4:0] buttons,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [3:0] hours,
  output logic [5:0] minutes,
  output logic [5:0] seconds
);

  tclk_pkg::cfg_write_t  cfg;
  tclk_pkg::event_t      ev;
  tclk_pkg::clock_time_t result;
  logic                  ev_valid;
  logic                  out_ready;
  logic                  fire;

  assign cfg.enable = write_enable;
  assign cfg.index  = tclk_pkg::reg_index_t'(write_index);
  assign cfg.data   = write_data;

  assign fire = ev_valid && out_ready;

  tclk_in_stage u_in_stage (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .opcode   (opcode),
    .buttons  (buttons),
    .take     (fire),
    .ev_valid (ev_valid),
    .ev       (ev)
  );

  tclk_core u_core (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .fire   (fire),
    .ev     (ev),
    .result (result)
  );

  tclk_out_stage u_out_stage (
    .clk       (clk),
    .rst       (rst),
    .load      (fire),
    .result    (result),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .hours     (hours),
    .minutes   (minutes),
    .seconds   (seconds)
  );

endmodule

// ===== src/tclk_checker.sv =====
// port-level checker for the twelve-hour clock and its bind
module tclk_checker (
  input logic       clk,
  input logic       rst,
  input logic       write_enable,
  input logic [1:0] write_index,
  input logic [9:0] write_data,
  input logic       in_valid,
  input logic       in_stall,
  input logic       opcode,
  input logic [4:0] buttons,
  input logic       out_valid,
  input logic       out_stall,
  input logic [3:0] hours,
  input logic [5:0] minutes,
  input logic [5:0] seconds
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(hours) && $stable(minutes)
      && $stable(seconds))
    else $error("stalled output word changed");

  a_hours_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> hours >= 4'd1 && hours <= 4'd12)
    else $error("hours out of range");

  a_min_sec_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> minutes <= 6'd59 && seconds <= 6'd59)
    else $error("minutes or seconds out of range");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled while output free");

  a_out_source: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && !$past(rst, 2) && $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
    else $error("output word without accepted input word");

endmodule

bind twelve_hour_clock_with_set_buttons tclk_checker u_tclk_checker (.*);

// ===== bench/tclk_time_checker.sv =====
// checker for the twelve-hour clock: tracks register writes, predicts each time word and compares
module tclk_time_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       write_enable,
  input  logic [1:0] write_index,
  input  logic [9:0] write_data,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic       opcode,
  input  logic [4:0] buttons,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [3:0] hours,
  input  logic [5:0] minutes,
  input  logic [5:0] seconds,
  output int         fail_count,
  output int         pending,
  output int         checked
);
  timeunit 1ns;
  timeprecision 1ps;

  tclk_pkg::reg_t        tps_cfg;
  tclk_pkg::debounce_t   debounce_cfg;
  tclk_pkg::reg_t        hold_cfg;
  tclk_pkg::reg_t        interval_cfg;

  tclk_pkg::clock_time_t now_time;
  tclk_pkg::count_t      subsec_cnt;
  tclk_pkg::count_t      hold_cnt;
  tclk_pkg::count_t      repeat_cnt;
  tclk_pkg::buttons_t    raw_btn;
  tclk_pkg::buttons_t    held_btn;
  tclk_pkg::debounce_t   debounce_left;

  tclk_pkg::clock_time_t expected_times[$];
  tclk_pkg::clock_time_t want;
  int                    errors_seen;
  int                    words_checked;

  function automatic logic [5:0] wrap_sixty(input logic [5:0] v, input logic up,
                                            input logic down);
    if (up) begin
      return (v >= tclk_pkg::SIXTY_LAST) ? 6'd0 : v + 6'd1;
    end
    if (down) begin
      return (v == 6'd0) ? tclk_pkg::SIXTY_LAST : v - 6'd1;
    end
    return v;
  endfunction

  function automatic tclk_pkg::clock_time_t nudge_time(input tclk_pkg::clock_time_t t,
                                                       input tclk_pkg::buttons_t b);
    logic                  up;
    logic                  down;
    tclk_pkg::clock_time_t r;
    up   = b[tclk_pkg::BTN_INC];
    down = b[tclk_pkg::BTN_DEC] && !b[tclk_pkg::BTN_INC];
    r    = t;
    if (b[tclk_pkg::BTN_MIN]) begin
      r.minutes = wrap_sixty(t.minutes, up, down);
    end
    if (b[tclk_pkg::BTN_SEC]) begin
      r.seconds = wrap_sixty(t.seconds, up, down);
    end
    if (b[tclk_pkg::BTN_HOUR]) begin
      if (up) begin
        r.hours = (t.hours >= tclk_pkg::HOUR_LAST) ? tclk_pkg::HOUR_FIRST : t.hours + 4'd1;
      end else if (down) begin
        r.hours = (t.hours <= tclk_pkg::HOUR_FIRST) ? tclk_pkg::HOUR_LAST : t.hours - 4'd1;
      end
    end
    return r;
  endfunction

  task automatic reset_clock_model();
    tps_cfg       = tclk_pkg::TPS_RESET;
    debounce_cfg  = tclk_pkg::DEBOUNCE_RESET;
    hold_cfg      = tclk_pkg::HOLD_RESET;
    interval_cfg  = tclk_pkg::INTERVAL_RESET;
    now_time      = '{hours: tclk_pkg::HOUR_FIRST, minutes: 6'd0, seconds: 6'd0};
    subsec_cnt    = '0;
    hold_cnt      = '0;
    repeat_cnt    = '0;
    raw_btn       = '0;
    held_btn      = '0;
    debounce_left = tclk_pkg::DEBOUNCE_RESET;
  endtask

  task automatic clock_tick();
    // free-running time only while no debounced button is held
    if (held_btn == '0) begin
      subsec_cnt = subsec_cnt + 1'b1;
      if (subsec_cnt >= tps_cfg) begin
        subsec_cnt = '0;
        now_time.seconds = now_time.seconds + 6'd1;
      end
      if (now_time.seconds > tclk_pkg::SIXTY_LAST) begin
        now_time.seconds = 6'd0;
        now_time.minutes = now_time.minutes + 6'd1;
      end
      if (now_time.minutes > tclk_pkg::SIXTY_LAST) begin
        now_time.minutes = 6'd0;
        now_time.hours = now_time.hours + 4'd1;
      end
      if (now_time.hours > tclk_pkg::HOUR_LAST) begin
        now_time.hours = tclk_pkg::HOUR_FIRST;
      end
    end
    if (debounce_left != '0) begin
      if (debounce_left == tclk_pkg::debounce_t'(1)) begin
        held_btn = raw_btn;
        now_time = nudge_time(now_time, held_btn);
      end
      debounce_left = debounce_left - 1'b1;
    end
    // auto repeat while held
    if (held_btn != '0 && debounce_left == '0) begin
      if (hold_cnt < hold_cfg) begin
        hold_cnt = hold_cnt + 1'b1;
      end else if (repeat_cnt < interval_cfg) begin
        repeat_cnt = repeat_cnt + 1'b1;
      end else begin
        repeat_cnt = '0;
        now_time = nudge_time(now_time, held_btn);
      end
    end else begin
      hold_cnt = '0;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      reset_clock_model();
      expected_times.delete();
      errors_seen   = 0;
      words_checked = 0;
    end else begin
      if (write_enable) begin
        case (tclk_pkg::reg_index_t'(write_index))
          tclk_pkg::REG_SECOND_LEN:            tps_cfg = write_data;
          tclk_pkg::REG_SETTLE_LEN:
            debounce_cfg = write_data[tclk_pkg::DEBOUNCE_WIDTH-1:0];
          tclk_pkg::REG_REPEAT_HOLD_TICKS:     hold_cfg = write_data;
          tclk_pkg::REG_REPEAT_INTERVAL_TICKS: interval_cfg = write_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        if (opcode == tclk_pkg::OP_BUTTON) begin
          raw_btn       = buttons;
          debounce_left = debounce_cfg;
        end else begin
          clock_tick();
        end
        expected_times.push_back(now_time);
      end
      if (out_valid && !out_stall) begin
        words_checked++;
        if (expected_times.size() == 0) begin
          $error("time word %0d:%0d:%0d with nothing expected", hours, minutes, seconds);
          errors_seen++;
        end else begin
          want = expected_times.pop_front();
          if (hours !== want.hours) begin
            $error("hours: expected %0d, actual %0d", want.hours, hours);
            errors_seen++;
          end
          if (minutes !== want.minutes) begin
            $error("minutes: expected %0d, actual %0d", want.minutes, minutes);
            errors_seen++;
          end
          if (seconds !== want.seconds) begin
            $error("seconds: expected %0d, actual %0d", want.seconds, seconds);
            errors_seen++;
          end
        end
      end
    end
    fail_count <= errors_seen;
    checked    <= words_checked;
    pending    <= expected_times.size();
  end

endmodule

// ===== bench/twelve_hour_clock_with_set_buttons_tb.sv =====
// testbench top for the twelve-hour clock: drives ticks, button words and register writes
module twelve_hour_clock_with_set_buttons_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RUN_LIMIT   = 500000;
  localparam int PHASE_WORDS = 75;
  localparam int PHASES      = 8;

  localparam tclk_pkg::buttons_t B_MIN  = tclk_pkg::buttons_t'(1 << tclk_pkg::BTN_MIN);
  localparam tclk_pkg::buttons_t B_SEC  = tclk_pkg::buttons_t'(1 << tclk_pkg::BTN_SEC);
  localparam tclk_pkg::buttons_t B_DEC  = tclk_pkg::buttons_t'(1 << tclk_pkg::BTN_DEC);
  localparam tclk_pkg::buttons_t B_HOUR = tclk_pkg::buttons_t'(1 << tclk_pkg::BTN_HOUR);
  localparam tclk_pkg::buttons_t B_INC  = tclk_pkg::buttons_t'(1 << tclk_pkg::BTN_INC);

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       write_enable = 1'b0;
  logic [1:0] write_index = tclk_pkg::REG_SECOND_LEN;
  logic [9:0] write_data = '0;
  logic       in_valid = 1'b0;
  logic       opcode = tclk_pkg::OP_TICK;
  logic [4:0] buttons = '0;
  logic       out_stall = 1'b0;
  logic       in_stall;
  logic       out_valid;
  logic [3:0] hours;
  logic [5:0] minutes;
  logic [5:0] seconds;

  int                  fail_count;
  int                  pending;
  int                  checked;
  int                  words_sent = 0;
  int                  settings_used = 0;
  int                  sequences = 0;
  int                  drains = 0;
  int                  cycle_count;
  bit                  gaps_on = 1'b1;
  bit                  stall_on = 1'b1;
  tclk_pkg::debounce_t cur_debounce = tclk_pkg::DEBOUNCE_RESET;
  tclk_pkg::reg_t      cur_hold = tclk_pkg::HOLD_RESET;
  tclk_pkg::reg_t      cur_interval = tclk_pkg::INTERVAL_RESET;

  twelve_hour_clock_with_set_buttons i_dut (
    .clk          (clk),
    .rst          (rst),
    .write_enable (write_enable),
    .write_index  (write_index),
    .write_data   (write_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .opcode       (opcode),
    .buttons      (buttons),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .hours        (hours),
    .minutes      (minutes),
    .seconds      (seconds)
  );

  tclk_time_checker i_checker (
    .clk          (clk),
    .rst          (rst),
    .write_enable (write_enable),
    .write_index  (write_index),
    .write_data   (write_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .opcode       (opcode),
    .buttons      (buttons),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .hours        (hours),
    .minutes      (minutes),
    .seconds      (seconds),
    .fail_count   (fail_count),
    .pending      (pending),
    .checked      (checked)
  );

  always #4 clk = ~clk;

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(15, 40);
  endfunction

  task automatic send_word(input tclk_pkg::opcode_t op, input tclk_pkg::buttons_t b);
    int gap;
    gap = gaps_on ? gap_len() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode   <= op;
    buttons  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
  endtask

  // hold off until every time word is back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    drains++;
  endtask

  task automatic configure(input tclk_pkg::reg_t tps, input tclk_pkg::debounce_t deb,
                           input tclk_pkg::reg_t hold, input tclk_pkg::reg_t interval);
    write_enable <= 1'b1;
    write_index  <= tclk_pkg::REG_SECOND_LEN;
    write_data   <= tps;
    @(posedge clk);
    // upper bits beyond the debounce width are junk
    write_index  <= tclk_pkg::REG_SETTLE_LEN;
    write_data   <= (tclk_pkg::reg_t'($urandom_range(0, 3)) << tclk_pkg::DEBOUNCE_WIDTH)
                    | tclk_pkg::reg_t'(deb);
    @(posedge clk);
    write_index  <= tclk_pkg::REG_REPEAT_HOLD_TICKS;
    write_data   <= hold;
    @(posedge clk);
    write_index  <= tclk_pkg::REG_REPEAT_INTERVAL_TICKS;
    write_data   <= interval;
    @(posedge clk);
    write_enable <= 1'b0;
    cur_debounce = deb;
    cur_hold     = hold;
    cur_interval = interval;
    settings_used++;
  endtask

  // press, wait out debounce and some repeats, then release
  task automatic button_sequence();
    tclk_pkg::buttons_t b;
    int                 n;
    b = tclk_pkg::buttons_t'($urandom);
    case ($urandom_range(0, 2))
      0:       b = b | B_MIN;
      1:       b = b | B_SEC;
      default: b = b | B_HOUR;
    endcase
    if (!b[tclk_pkg::BTN_INC] && !b[tclk_pkg::BTN_DEC] && $urandom_range(0, 3) != 0) begin
      b = b | ($urandom_range(0, 1) ? B_INC : B_DEC);
    end
    send_word(tclk_pkg::OP_BUTTON, b);
    if ($urandom_range(0, 4) == 0) begin
      send_word(tclk_pkg::OP_TICK, tclk_pkg::buttons_t'($urandom));
      send_word(tclk_pkg::OP_BUTTON, b);
    end
    n = cur_debounce + cur_hold + $urandom_range(0, 3) * (cur_interval + 1)
        + $urandom_range(0, 2);
    if (n > 45) n = 45;
    repeat (n) send_word(tclk_pkg::OP_TICK, tclk_pkg::buttons_t'($urandom));
    send_word(tclk_pkg::OP_BUTTON, '0);
    n = cur_debounce + $urandom_range(0, 8);
    if (n > 45) n = 45;
    repeat (n) send_word(tclk_pkg::OP_TICK, tclk_pkg::buttons_t'($urandom));
    sequences++;
  endtask

  initial begin
    int run_left;
    bit level;
    run_left = 0;
    level    = 1'b0;
    wait (rst == 1'b0);
    forever begin
      @(posedge clk);
      if (run_left == 0) begin
        if (!level && stall_on) begin
          level    = 1'b1;
          run_left = gap_len() + 1;
        end else begin
          level    = 1'b0;
          run_left = $urandom_range(1, 12);
        end
      end
      run_left--;
      out_stall <= level;
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < RUN_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d time words outstanding", cycle_count, pending);
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    int start;
    int r;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed: reset settings, wraps, inc over dec, no select, release, zero settings
    send_word(tclk_pkg::OP_TICK, '0);
    drain();
    configure(tclk_pkg::reg_t'(1), tclk_pkg::debounce_t'(1), tclk_pkg::reg_t'(3),
              tclk_pkg::reg_t'(1));
    send_word(tclk_pkg::OP_BUTTON, B_MIN | B_SEC | B_HOUR | B_DEC);
    send_word(tclk_pkg::OP_TICK, '0);
    send_word(tclk_pkg::OP_BUTTON, '0);
    send_word(tclk_pkg::OP_TICK, '0);
    send_word(tclk_pkg::OP_TICK, '1);
    send_word(tclk_pkg::OP_BUTTON, '1);
    repeat (6) send_word(tclk_pkg::OP_TICK, '0);
    send_word(tclk_pkg::OP_BUTTON, B_DEC);
    send_word(tclk_pkg::OP_TICK, '0);
    send_word(tclk_pkg::OP_BUTTON, B_INC);
    send_word(tclk_pkg::OP_TICK, '0);
    send_word(tclk_pkg::OP_BUTTON, '0);
    send_word(tclk_pkg::OP_TICK, '0);
    send_word(tclk_pkg::OP_TICK, '0);
    drain();
    configure('0, '0, '0, '0);
    send_word(tclk_pkg::OP_BUTTON, B_MIN | B_INC);
    repeat (3) send_word(tclk_pkg::OP_TICK, '0);

    for (int p = 0; p < PHASES; p++) begin
      drain();
      case (p)
        0:       configure(tclk_pkg::reg_t'(1000), tclk_pkg::debounce_t'(255),
                           tclk_pkg::reg_t'(1000), tclk_pkg::reg_t'(1000));
        1:       configure(tclk_pkg::reg_t'(1), tclk_pkg::debounce_t'(1), '0, '0);
        default: configure(tclk_pkg::reg_t'($urandom_range(0, 3)),
                           tclk_pkg::debounce_t'($urandom_range(1, 4)),
                           tclk_pkg::reg_t'($urandom_range(0, 6)),
                           tclk_pkg::reg_t'($urandom_range(0, 5)));
      endcase
      gaps_on  = (p == 1) ? 1'b0 : ($urandom_range(0, 3) != 0);
      stall_on = (p == 1) ? 1'b0 : ($urandom_range(0, 3) != 0);
      start = words_sent;
      while (words_sent - start < PHASE_WORDS) begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          button_sequence();
        end else if (r < 95) begin
          repeat ($urandom_range(1, 5))
            send_word(tclk_pkg::opcode_t'($urandom_range(0, 1)),
                      tclk_pkg::buttons_t'($urandom));
        end else begin
          drain();
        end
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("%0d words sent (%0d button sequences) under %0d register settings",
             words_sent, sequences, settings_used);
    $display("%0d time words checked, %0d drain pauses, %0d cycles", checked, drains,
             cycle_count);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
